// ===== rtl/dffc_pkg.sv =====
// Shared types, constants and anchor geometry for the dipole field fit cost block.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package dffc_pkg;

	localparam int POS_W           = 19;
	localparam int VOLT_W          = 32;
	localparam int COST_W          = 48;
	localparam int SCALE_W         = 32;
	localparam int KHZ_W           = 8;
	localparam int SF_W            = SCALE_W + KHZ_W;
	localparam int QUO_W           = 32;
	localparam int RATIO_BITS      = 30;
	localparam int ROOT_EXTRA      = 7;
	localparam int MAX_ANCHORS     = 4;
	localparam int NUM_ANCHORS_DEF = 4;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int CFG_IDX_W       = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MEAS_A      = 3'd0,
		REG_MEAS_B      = 3'd1,
		REG_MEAS_C      = 3'd2,
		REG_MEAS_D      = 3'd3,
		REG_FIELD_SCALE = 3'd4
	} cfg_reg_t;

	// coil frequency of each anchor in kHz
	localparam logic [KHZ_W-1:0] ANCHOR_KHZ [MAX_ANCHORS] = '{8'd213, 8'd203, 8'd193, 8'd183};

	// anchors sit at (-+0.5 m, -+0.25 m, 0) in units of 2^-frac
	function automatic int anchor_x(input int idx, input int frac);
		int mag;
		mag = 1 << (frac - 1);
		return (idx == 0 || idx == 3) ? -mag : mag;
	endfunction

	function automatic int anchor_y(input int idx, input int frac);
		int mag;
		mag = 1 << (frac - 2);
		return (idx < 2) ? -mag : mag;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/dffc_if.sv =====
// Valid/ready channel interfaces: candidate position in, fit result out.
// Depends on dffc_pkg for field widths.
`default_nettype none
interface dffc_pos_if import dffc_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [POS_W-1:0] pos_x;
	logic signed [POS_W-1:0] pos_y;
	logic signed [POS_W-1:0] pos_z;

	modport source(output valid, output pos_x, output pos_y, output pos_z, input ready);
	modport sink(input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

interface dffc_res_if import dffc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [COST_W-1:0] cost_value;
	logic [VOLT_W-1:0] pred_volt_a;
	logic [VOLT_W-1:0] pred_volt_b;
	logic [VOLT_W-1:0] pred_volt_c;
	logic [VOLT_W-1:0] pred_volt_d;
	logic              zero_range_flag;

	modport source(output valid, output cost_value, output pred_volt_a, output pred_volt_b,
		output pred_volt_c, output pred_volt_d, output zero_range_flag, input ready);
	modport sink(input valid, input cost_value, input pred_volt_a, input pred_volt_b,
		input pred_volt_c, input pred_volt_d, input zero_range_flag, output ready);
endinterface
`default_nettype wire

// ===== rtl/dffc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, saturating quotient.
// Depends on dffc_pkg.
`default_nettype none
module dffc_div import dffc_pkg::*; #(
	parameter int NW = 70,
	parameter int DW = 41,
	parameter int QB = QUO_W,
	parameter int TW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_v,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [TW-1:0] tag_i,
	output logic          out_v,
	output logic [QB-1:0] quo,
	output logic [TW-1:0] tag_o
);
	localparam int AW = (NW > DW + QB) ? NW : DW + QB;

	logic [AW-1:0] rem_s [QB];
	logic [DW-1:0] den_s [QB];
	logic [QB-1:0] quo_s [1:QB];
	logic [TW-1:0] tag_s [QB+1];
	logic [QB:0]   sat_s;
	logic [QB:0]   vld_s;

	logic [AW-1:0] sh_c [QB];
	logic [QB-1:0] take_c;
	logic          sat_c;

	assign sat_c = (den == '0) || (AW'(num) >= (AW'(den) << QB));

	always_comb begin
		for (int j = 0; j < QB; j++) begin
			sh_c[j]   = AW'(den_s[j]) << (QB - 1 - j);
			take_c[j] = rem_s[j] >= sh_c[j];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[QB-1:0], in_v};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= AW'(num);
			den_s[0] <= den;
			tag_s[0] <= tag_i;
			sat_s[0] <= sat_c;
			quo_s[1] <= take_c[0] ? (QB'(1) << (QB - 1)) : '0;
			for (int j = 1; j < QB; j++) begin
				rem_s[j]   <= take_c[j-1] ? rem_s[j-1] - sh_c[j-1] : rem_s[j-1];
				den_s[j]   <= den_s[j-1];
				quo_s[j+1] <= quo_s[j] | (take_c[j] ? (QB'(1) << (QB - 1 - j)) : '0);
			end
			for (int j = 1; j <= QB; j++) begin
				tag_s[j] <= tag_s[j-1];
				sat_s[j] <= sat_s[j-1];
			end
		end
	end

	assign out_v = vld_s[QB];
	assign quo   = sat_s[QB] ? '1 : quo_s[QB];
	assign tag_o = tag_s[QB];
endmodule
`default_nettype wire

// ===== rtl/dffc_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
// Depends on dffc_pkg.
`default_nettype none
module dffc_sqrt import dffc_pkg::*; #(
	parameter int SW = 56,
	parameter int TW = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_v,
	input  logic [SW-1:0]   rad,
	input  logic [TW-1:0]   tag_i,
	output logic            out_v,
	output logic [SW/2-1:0] root,
	output logic [TW-1:0]   tag_o
);
	localparam int RW = SW / 2;

	logic [SW-1:0] rem_s [RW-1];
	logic [SW-1:0] res_s [RW];
	logic [TW-1:0] tag_s [RW];
	logic [RW-1:0] vld_s;

	logic [SW-1:0] rin_c [RW];
	logic [SW-1:0] qin_c [RW];
	logic [SW-1:0] bit_c [RW];
	logic [SW-1:0] trial_c [RW];
	logic [RW-1:0] take_c;

	always_comb begin
		rin_c[0] = rad;
		qin_c[0] = '0;
		for (int k = 1; k < RW; k++) begin
			rin_c[k] = rem_s[k-1];
			qin_c[k] = res_s[k-1];
		end
		for (int k = 0; k < RW; k++) begin
			bit_c[k]   = SW'(1) << (SW - 2 - 2 * k);
			trial_c[k] = qin_c[k] + bit_c[k];
			take_c[k]  = rin_c[k] >= trial_c[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[RW-2:0], in_v};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s[0] <= tag_i;
			for (int k = 1; k < RW; k++) begin
				tag_s[k] <= tag_s[k-1];
			end
			for (int k = 0; k < RW - 1; k++) begin
				rem_s[k] <= take_c[k] ? rin_c[k] - trial_c[k] : rin_c[k];
			end
			for (int k = 0; k < RW; k++) begin
				res_s[k] <= take_c[k] ? (qin_c[k] >> 1) + bit_c[k] : qin_c[k] >> 1;
			end
		end
	end

	assign out_v = vld_s[RW-1];
	assign root  = res_s[RW-1][RW-1:0];
	assign tag_o = tag_s[RW-1];
endmodule
`default_nettype wire

// ===== rtl/dffc_lane.sv =====
// One anchor lane: offsets, squares, angular ratio, range root and voltage divide.
// Depends on dffc_pkg, dffc_sqrt and dffc_div.
`default_nettype none
module dffc_lane import dffc_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int IDX       = 0
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_v,
	input  logic signed [POS_W-1:0] pos_x,
	input  logic signed [POS_W-1:0] pos_y,
	input  logic signed [POS_W-1:0] pos_z,
	input  logic [SF_W-1:0]         scale_khz,
	output logic                    out_v,
	output logic [VOLT_W-1:0]       pred,
	output logic                    zero
);
	localparam int DXW = ((POS_W > FRAC_BITS + 1) ? POS_W : FRAC_BITS + 1) + 1;
	localparam int QW  = 2 * DXW - 1;
	localparam int D2W = QW + 2;
	localparam int NW  = QW + 1;
	localparam int SWR = D2W + 2 * ROOT_EXTRA;
	localparam int SWE = SWR + (SWR % 2);
	localparam int RW  = SWE / 2;
	localparam int VSH = 3 * FRAC_BITS + ROOT_EXTRA - RATIO_BITS;
	localparam int PW  = QUO_W + SF_W;
	localparam int VNW = PW + VSH;
	localparam int VDW = D2W + RW;
	localparam int AX  = anchor_x(IDX, FRAC_BITS);
	localparam int AY  = anchor_y(IDX, FRAC_BITS);

	// offsets: anchor minus candidate
	logic signed [DXW-1:0] dx_s1, dy_s1, dz_s1;
	logic                  v_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= DXW'(AX) - DXW'(pos_x);
			dy_s1 <= DXW'(AY) - DXW'(pos_y);
			dz_s1 <= -DXW'(pos_z);
		end
	end

	// squares
	logic signed [2*DXW-1:0] sqx_c, sqy_c, sqz_c;
	logic [QW-1:0]           qx_s2, qy_s2, qz_s2;
	logic                    v_s2;

	assign sqx_c = dx_s1 * dx_s1;
	assign sqy_c = dy_s1 * dy_s1;
	assign sqz_c = dz_s1 * dz_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			qx_s2 <= sqx_c[QW-1:0];
			qy_s2 <= sqy_c[QW-1:0];
			qz_s2 <= sqz_c[QW-1:0];
		end
	end

	// range squared and |2dz^2 - dx^2 - dy^2|
	logic [D2W-1:0] d2_c, d2_s3;
	logic [NW-1:0]  a_c, b_c, n_c, n_s3;
	logic           zero_s3, v_s3;

	assign d2_c = D2W'(qx_s2) + D2W'(qy_s2) + D2W'(qz_s2);
	assign a_c  = {qz_s2, 1'b0};
	assign b_c  = NW'(qx_s2) + NW'(qy_s2);
	assign n_c  = (a_c >= b_c) ? a_c - b_c : b_c - a_c;

	always_ff @(posedge clk) begin
		if (en) begin
			d2_s3   <= d2_c;
			n_s3    <= n_c;
			zero_s3 <= (d2_c == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// range root
	localparam int STW = NW + D2W + 1;
	logic [STW-1:0] sq_tag;
	logic [RW-1:0]  root;
	logic           sq_v;
	logic [NW-1:0]  n_r;
	logic [D2W-1:0] d2_r;
	logic           zero_r;

	dffc_sqrt #(.SW(SWE), .TW(STW)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(v_s3),
		.rad(SWE'({d2_s3, {(2 * ROOT_EXTRA){1'b0}}})),
		.tag_i({n_s3, d2_s3, zero_s3}),
		.out_v(sq_v), .root(root), .tag_o(sq_tag)
	);

	assign {n_r, d2_r, zero_r} = sq_tag;

	// angular ratio n / d2 in Q.30
	localparam int CTW = D2W + RW + 1;
	logic [CTW-1:0]   c_tag;
	logic [QUO_W-1:0] cq;
	logic             c_v;
	logic [D2W-1:0]   d2_q;
	logic [RW-1:0]    r_q;
	logic             zero_q;

	dffc_div #(.NW(NW + RATIO_BITS), .DW(D2W), .QB(QUO_W), .TW(CTW)) u_ratio (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(sq_v),
		.num({n_r, {RATIO_BITS{1'b0}}}), .den(d2_r),
		.tag_i({d2_r, root, zero_r}),
		.out_v(c_v), .quo(cq), .tag_o(c_tag)
	);

	assign {d2_q, r_q, zero_q} = c_tag;

	// partial products of scale*f*c and d2*r
	logic [2*QUO_W-1:0]   pl_s4;
	logic [SF_W-1:0]      ph_s4;
	logic [32+RW-1:0]     dl_s4;
	logic [D2W-32+RW-1:0] dh_s4;
	logic                 zero_s4, v_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			pl_s4   <= cq * scale_khz[31:0];
			ph_s4   <= cq * scale_khz[SF_W-1:32];
			dl_s4   <= d2_q[31:0] * r_q;
			dh_s4   <= d2_q[D2W-1:32] * r_q;
			zero_s4 <= zero_q;
		end
	end

	// sum partials, scale numerator
	logic [PW-1:0]  vprod_c;
	logic [VNW-1:0] vnum_s5;
	logic [VDW-1:0] vden_s5;
	logic           zero_s5, v_s5;

	assign vprod_c = (PW'(ph_s4) << 32) + PW'(pl_s4);

	always_ff @(posedge clk) begin
		if (en) begin
			vnum_s5 <= VNW'(vprod_c) << VSH;
			vden_s5 <= (VDW'(dh_s4) << 32) + VDW'(dl_s4);
			zero_s5 <= zero_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s4 <= c_v;
			v_s5 <= v_s4;
		end
	end

	// voltage divide; a zero range gives a zero divisor and saturates
	dffc_div #(.NW(VNW), .DW(VDW), .QB(VOLT_W), .TW(1)) u_volt (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(v_s5),
		.num(vnum_s5), .den(vden_s5), .tag_i(zero_s5),
		.out_v(out_v), .quo(pred), .tag_o(zero)
	);
endmodule
`default_nettype wire

// ===== rtl/dipole_field_fit_cost.sv =====
// Top level of the dipole field fit cost evaluator.
// Depends on dffc_pkg, dffc_if and dffc_lane (which uses dffc_sqrt and dffc_div).
`default_nettype none
// The block takes one candidate tag position per transaction on cand and returns,
// per transaction on result, the predicted coil voltage of every anchor under a z-axis
// magnetic dipole model together with the saturating sum of squared errors against
// the four measured voltages held in the configuration registers. It accepts one
// transaction every clock while result.ready does not hold the pipeline. Each lane
// runs offset, square and range stages, R = DXW + 8 root stages of one bit each (DXW
// being the offset width, 20 at the default FRAC_BITS), a pipelined 32-bit ratio
// divider, the partial product and sum stages and a pipelined 32-bit voltage divider
// (one quotient bit per stage); the cost stages follow. The whole pipeline advances
// on one enable: while a result waits on result.ready every stage holds, and
// cand.ready falls with it. Configuration writes on wr_en/wr_index/wr_data take effect
// at once; write them while no transaction is in flight. A candidate that lands on an
// anchor saturates that anchor's voltage and raises zero_range_flag. Anchors at
// NUM_ANCHORS and above report zero and add nothing to the cost.
module dipole_field_fit_cost import dffc_pkg::*; #(
	parameter int NUM_ANCHORS = NUM_ANCHORS_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	dffc_pos_if.sink             cand,
	dffc_res_if.source           result,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [SCALE_W-1:0]   wr_data
);
	localparam int TMW  = 2 * VOLT_W - FRAC_BITS;
	localparam int SUMW = (TMW + 2 > COST_W) ? TMW + 2 : COST_W + 1;

	// configuration registers
	logic [VOLT_W-1:0]  meas_q [MAX_ANCHORS];
	logic [SCALE_W-1:0] scale_q;
	logic [SF_W-1:0]    sf_q [NUM_ANCHORS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_ANCHORS; i++) begin
				meas_q[i] <= '0;
			end
			scale_q <= SCALE_W'(1) << FRAC_BITS;
		end else if (wr_en) begin
			unique case (cfg_reg_t'(wr_index))
				REG_MEAS_A:      meas_q[0] <= wr_data;
				REG_MEAS_B:      meas_q[1] <= wr_data;
				REG_MEAS_C:      meas_q[2] <= wr_data;
				REG_MEAS_D:      meas_q[3] <= wr_data;
				REG_FIELD_SCALE: scale_q   <= wr_data;
				default: ;
			endcase
		end
	end

	// fold each anchor's frequency into the scale in a register, off the item path
	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_ANCHORS; i++) begin
			sf_q[i] <= scale_q * ANCHOR_KHZ[i];
		end
	end

	// global advance: hold everything while a result waits
	logic en;
	logic v_s3;

	assign en         = !v_s3 || result.ready;
	assign cand.ready = en;

	// anchor lanes
	logic [NUM_ANCHORS-1:0] lane_v;
	logic [VOLT_W-1:0]      lane_pred [MAX_ANCHORS];
	logic [MAX_ANCHORS-1:0] lane_zero;

	for (genvar i = 0; i < MAX_ANCHORS; i++) begin : g_lane
		if (i < NUM_ANCHORS) begin : g_used
			dffc_lane #(.FRAC_BITS(FRAC_BITS), .IDX(i)) u_lane (
				.clk(clk), .arst_n(arst_n), .en(en), .in_v(cand.valid),
				.pos_x(cand.pos_x), .pos_y(cand.pos_y), .pos_z(cand.pos_z),
				.scale_khz(sf_q[i]),
				.out_v(lane_v[i]), .pred(lane_pred[i]), .zero(lane_zero[i])
			);
		end else begin : g_unused
			assign lane_pred[i] = '0;
			assign lane_zero[i] = 1'b0;
		end
	end

	// cost stage 1: absolute errors
	logic [VOLT_W-1:0] diff_s1 [MAX_ANCHORS];
	logic [VOLT_W-1:0] pred_s1 [MAX_ANCHORS];
	logic              flag_s1, v_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < MAX_ANCHORS; i++) begin
				diff_s1[i] <= (lane_pred[i] >= meas_q[i]) ? lane_pred[i] - meas_q[i]
				                                          : meas_q[i] - lane_pred[i];
				pred_s1[i] <= lane_pred[i];
			end
			flag_s1 <= |lane_zero;
		end
	end

	// cost stage 2: squared errors, drop unused anchors
	logic [2*VOLT_W-1:0] sq_c [MAX_ANCHORS];
	logic [TMW-1:0]      term_s2 [MAX_ANCHORS];
	logic [VOLT_W-1:0]   pred_s2 [MAX_ANCHORS];
	logic                flag_s2, v_s2;

	always_comb begin
		for (int i = 0; i < MAX_ANCHORS; i++) begin
			sq_c[i] = diff_s1[i] * diff_s1[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < MAX_ANCHORS; i++) begin
				term_s2[i] <= (i < NUM_ANCHORS) ? sq_c[i][2*VOLT_W-1:FRAC_BITS] : '0;
				pred_s2[i] <= pred_s1[i];
			end
			flag_s2 <= flag_s1;
		end
	end

	// cost stage 3: sum and clip; this is the output register
	logic [SUMW-1:0]   sum_c;
	logic [COST_W-1:0] cost_s3;
	logic [VOLT_W-1:0] pred_s3 [MAX_ANCHORS];
	logic              flag_s3;

	always_comb begin
		sum_c = '0;
		for (int i = 0; i < MAX_ANCHORS; i++) begin
			sum_c = sum_c + SUMW'(term_s2[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cost_s3 <= (|sum_c[SUMW-1:COST_W]) ? '1 : sum_c[COST_W-1:0];
			for (int i = 0; i < MAX_ANCHORS; i++) begin
				pred_s3[i] <= pred_s2[i];
			end
			flag_s3 <= flag_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= lane_v[0];
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign result.valid           = v_s3;
	assign result.cost_value      = cost_s3;
	assign result.pred_volt_a     = pred_s3[0];
	assign result.pred_volt_b     = pred_s3[1];
	assign result.pred_volt_c     = pred_s3[2];
	assign result.pred_volt_d     = pred_s3[3];
	assign result.zero_range_flag = flag_s3;

	// all lanes share one latency, so their valid bits must agree
	a_lanes_in_step: assert property (@(posedge clk) disable iff (!arst_n)
		(&lane_v) || !(|lane_v))
		else $error("anchor lanes out of step");

	// a coincident anchor always shows up as a saturated voltage
	a_flag_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && flag_s3) |-> (pred_s3[0] == '1 || pred_s3[1] == '1 ||
		                        pred_s3[2] == '1 || pred_s3[3] == '1))
		else $error("zero range flag without saturated voltage");

endmodule
`default_nettype wire
